[rtl/pli_pkg.sv]
package pli_pkg;

  // Quotient bits of the interpolation weight t (unsigned Q0.16)
  localparam int unsigned TBits = 16;

  // Result region codes
  localparam logic [1:0] RegionInterp = 2'd0;
  localparam logic [1:0] RegionBelow  = 2'd1;
  localparam logic [1:0] RegionAbove  = 2'd2;

  // Register map (word index)
  localparam logic RegPointsInUse = 1'b0;

  localparam logic [4:0] PointsInUseReset = 5'd2;

endpackage

[rtl/pli_select.sv]
module pli_select #(
  parameter int unsigned NP = 16,
  parameter int unsigned VW = 16
) (
  input  logic [4:0]           pts_i,
  input  logic signed [VW-1:0] x_i,
  input  logic signed [VW-1:0] xs_i [NP],
  input  logic signed [VW-1:0] ys_i [NP],
  output logic [1:0]           region_o,
  output logic signed [VW-1:0] y0_o,
  output logic signed [VW:0]   dy_o,
  output logic [VW:0]          dx_o,
  output logic [VW:0]          span_o
);
  import pli_pkg::*;

  localparam int unsigned IW = (NP > 1) ? $clog2(NP) : 1;
  localparam logic [8:0] NMax = 9'(NP);

  logic [8:0]           n;
  logic [IW-1:0]        last;
  logic [IW-1:0]        sel;
  logic [IW-1:0]        sel_m1;
  logic                 found;
  logic signed [VW-1:0] x0, x1, y0, y1;

  // Clamp the number of points in use
  always_comb begin
    if (pts_i < 5'd2) begin
      n = 9'd2;
    end else if (9'(pts_i) > NMax) begin
      n = NMax;
    end else begin
      n = 9'(pts_i);
    end
    last = IW'(n - 9'd1);
  end

  // First breakpoint at or above x (priority toward the low index)
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = NP - 1; i >= 1; i--) begin
      if ((9'(i) < n) && (x_i <= xs_i[i])) begin
        found = 1'b1;
        sel   = IW'(i);
      end
    end
    sel_m1 = sel - IW'(1);
  end

  assign x0 = xs_i[sel_m1];
  assign x1 = xs_i[sel];
  assign y0 = ys_i[sel_m1];
  assign y1 = ys_i[sel];

  // Clamped and exact cases become y0 with a zero slope
  always_comb begin
    region_o = RegionInterp;
    y0_o     = y0;
    dy_o     = '0;
    dx_o     = '0;
    span_o   = (VW+1)'(1);
    if (x_i <= xs_i[0]) begin
      region_o = RegionBelow;
      y0_o     = ys_i[0];
    end else if (x_i >= xs_i[last] || !found) begin
      region_o = RegionAbove;
      y0_o     = ys_i[last];
    end else if (x_i == x1) begin
      y0_o = y1;
    end else begin
      dy_o   = (VW+1)'({y1[VW-1], y1} - {y0[VW-1], y0});
      dx_o   = (VW+1)'({x_i[VW-1], x_i} - {x0[VW-1], x0});
      span_o = (VW+1)'({x1[VW-1], x1} - {x0[VW-1], x0});
    end
  end

endmodule

[rtl/pli_div_stage.sv]
module pli_div_stage #(
  parameter int unsigned VW = 16,
  parameter int unsigned SW = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [VW+1:0]              rem_i,
  input  logic [VW:0]                span_i,
  input  logic [pli_pkg::TBits-1:0]  quo_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [VW+1:0]              rem_o,
  output logic [VW:0]                span_o,
  output logic [pli_pkg::TBits-1:0]  quo_o,
  output logic [SW-1:0]              side_o
);
  import pli_pkg::*;

  logic                v_q;
  logic [VW+1:0]       rem_q, rem_d, shifted;
  logic [VW:0]         span_q;
  logic [TBits-1:0]    quo_q, quo_d;
  logic [SW-1:0]       side_q;
  logic                ge;

  assign ready_o = !v_q || ready_i;

  // One restoring division step: one quotient bit
  always_comb begin
    shifted = {rem_i[VW:0], 1'b0};
    ge      = shifted >= {1'b0, span_i};
    rem_d   = ge ? (shifted - {1'b0, span_i}) : shifted;
    quo_d   = {quo_i[TBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      span_q <= span_i;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = v_q;
  assign rem_o   = rem_q;
  assign span_o  = span_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

[rtl/pli_output.sv]
module pli_output #(
  parameter int unsigned VW = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [pli_pkg::TBits-1:0] t_i,
  input  logic [1:0]                region_i,
  input  logic signed [VW-1:0]      y0_i,
  input  logic signed [VW:0]        dy_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic signed [VW-1:0]      y_o,
  output logic [1:0]                region_o
);
  import pli_pkg::*;

  localparam int unsigned PW = VW + TBits + 2;
  localparam logic signed [VW+1:0] YMax = (VW+2)'((1 << (VW - 1)) - 1);
  localparam logic signed [VW+1:0] YMin = -YMax - (VW+2)'(1);

  logic                  m_v_q, o_v_q, m_ready;
  logic signed [PW-1:0]  prod_q;
  logic signed [VW-1:0]  m_y0_q;
  logic [1:0]            m_region_q;
  logic signed [VW+1:0]  sum;
  logic signed [VW-1:0]  y_q, y_d;
  logic [1:0]            region_q;

  function automatic logic signed [VW+1:0] y0_ext(input logic signed [VW-1:0] v);
    y0_ext = {{2{v[VW-1]}}, v};
  endfunction

  assign ready_o = !m_v_q || m_ready;
  assign m_ready = !o_v_q || ready_i;

  // Multiply stage: t * (y1 - y0)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (ready_o) begin
      m_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q     <= PW'($signed({1'b0, t_i}) * dy_i);
      m_y0_q     <= y0_i;
      m_region_q <= region_i;
    end
  end

  // Add stage: y0 + floor(product / 2^16), saturated
  always_comb begin
    sum = (VW+2)'(y0_ext(m_y0_q)) + $signed(prod_q[PW-1:TBits]);
    if (sum > YMax) begin
      y_d = YMax[VW-1:0];
    end else if (sum < YMin) begin
      y_d = YMin[VW-1:0];
    end else begin
      y_d = sum[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (m_ready) begin
      o_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_ready && m_v_q) begin
      y_q      <= y_d;
      region_q <= m_region_q;
    end
  end

  assign valid_o  = o_v_q;
  assign y_o      = y_q;
  assign region_o = region_q;

endmodule

[rtl/piecewise_linear_interpolator.sv]
// Channel   Direction  Handshake                  Word
// in        input      in_valid_i / in_ready_o    action, point_index, point_x, point_y, x_in
// out       output     out_valid_o / out_ready_i  y_out, region
// cfg       input      APB (psel, penable, ...)   points_in_use at byte address 0
//
// A query passes through one select stage, 16 divider stages (one quotient bit
// each), one multiply stage and the result register, which takes the add.
// A new word can be accepted every cycle unless a stall backs up to the input; a load writes its slot at accept.
// A stall backs up stage by stage; empty stages keep taking words.
// Reset clears valid bits and points_in_use (to 2); the table needs loading.
module piecewise_linear_interpolator #(
  parameter int unsigned MAX_POINTS  = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [3:0]                    point_index_i,
  input  logic signed [VALUE_WIDTH-1:0] point_x_i,
  input  logic signed [VALUE_WIDTH-1:0] point_y_i,
  input  logic signed [VALUE_WIDTH-1:0] x_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] y_out_o,
  output logic [1:0]                    region_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pli_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned SW = 2 + VW + VW + 1;
  localparam int unsigned NS = TBits;

  logic [4:0]           pts_q;
  logic signed [VW-1:0] xs_q [MAX_POINTS];
  logic signed [VW-1:0] ys_q [MAX_POINTS];

  logic                 accept;
  logic [1:0]           sel_region;
  logic signed [VW-1:0] sel_y0;
  logic signed [VW:0]   sel_dy;
  logic [VW:0]          sel_dx, sel_span;

  logic                 s0_v_q;
  logic [VW+1:0]        s0_rem_q;
  logic [VW:0]          s0_span_q;
  logic [SW-1:0]        s0_side_q;

  logic                 dv    [NS+1];
  logic                 dr    [NS+1];
  logic [VW+1:0]        drem  [NS+1];
  logic [VW:0]          dspan [NS+1];
  logic [TBits-1:0]     dquo  [NS+1];
  logic [SW-1:0]        dside [NS+1];

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPointsInUse && paddr[1:0] == 2'd0) ? {27'd0, pts_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q <= PointsInUseReset;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == RegPointsInUse && paddr[1:0] == 2'd0) begin
      pts_q <= pwdata[4:0];
    end
  end

  // Input side: loads write the table at accept
  assign in_ready_o = !s0_v_q || dr[0];
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (accept && !action_i && int'(point_index_i) == k) begin
        xs_q[k] <= point_x_i;
        ys_q[k] <= point_y_i;
      end
    end
  end

  // Segment search and operand selection
  pli_select #(.NP(MAX_POINTS), .VW(VW)) u_select (
    .pts_i    (pts_q),
    .x_i      (x_in_i),
    .xs_i     (xs_q),
    .ys_i     (ys_q),
    .region_o (sel_region),
    .y0_o     (sel_y0),
    .dy_o     (sel_dy),
    .dx_o     (sel_dx),
    .span_o   (sel_span)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_v_q <= accept && action_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && action_i) begin
      s0_rem_q  <= {1'b0, sel_dx};
      s0_span_q <= sel_span;
      s0_side_q <= {sel_region, sel_y0, sel_dy};
    end
  end

  assign dv[0]    = s0_v_q;
  assign drem[0]  = s0_rem_q;
  assign dspan[0] = s0_span_q;
  assign dquo[0]  = '0;
  assign dside[0] = s0_side_q;

  // Pipelined divider: t = (dx << 16) / span
  for (genvar g = 0; g < NS; g++) begin : g_div
    pli_div_stage #(.VW(VW), .SW(SW)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[g]),
      .ready_o (dr[g]),
      .rem_i   (drem[g]),
      .span_i  (dspan[g]),
      .quo_i   (dquo[g]),
      .side_i  (dside[g]),
      .valid_o (dv[g+1]),
      .ready_i (dr[g+1]),
      .rem_o   (drem[g+1]),
      .span_o  (dspan[g+1]),
      .quo_o   (dquo[g+1]),
      .side_o  (dside[g+1])
    );
  end

  // Multiply, add and result register
  pli_output #(.VW(VW)) u_output (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dv[NS]),
    .ready_o  (dr[NS]),
    .t_i      (dquo[NS]),
    .region_i (dside[NS][SW-1 -: 2]),
    .y0_i     (dside[NS][VW+VW:VW+1]),
    .dy_i     (dside[NS][VW:0]),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .y_o      (y_out_o),
    .region_o (region_o)
  );

endmodule

[rtl/pli_checker.sv]
module pli_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  region_o,
  input logic        pready
);
  import pli_pkg::*;

  // A held word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out word dropped while stalled");

  // A held word keeps its region
  a_region_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(region_o))
    else $error("region changed while stalled");

  // An empty output register means the pipeline can take a word
  a_no_dead_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // Only defined region codes leave the block
  a_region_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (region_o == RegionInterp || region_o == RegionBelow
                     || region_o == RegionAbove))
    else $error("bad region code");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .region_o    (region_o),
  .pready      (pready)
);
